@@ hw/rtl/alc_pkg.sv @@
// Shared types, constants and decode functions for the ambient light lux converter.
`default_nettype none

package alc_pkg;

    localparam int RAW_W   = 16;
    localparam int LUX_W   = 27;
    localparam int CFG_W   = 4;
    localparam int GAIN_W  = 2;
    localparam int INTEG_W = 4;
    localparam int K_W     = 4;
    localparam int Y_W     = 25;
    localparam int X_W     = 29;
    localparam int RECIP_W = 30;
    localparam int PROD_W  = 59;
    localparam int RECIP_SHIFT = 41;
    localparam int LIN_W   = 17;

    localparam int C4_W = 20;
    localparam int C3_W = 34;
    localparam int C2_W = 47;
    localparam int C1_W = 61;

    localparam int T1_W = 38;
    localparam int T1_LO_W = 19;
    localparam int PA_W = T1_LO_W + LIN_W;
    localparam int PB_W = T1_W - T1_LO_W + LIN_W + 1;

    localparam int T2_W = 57;
    localparam int T2_LO_W = 28;
    localparam int QA_W = T2_LO_W + LIN_W;
    localparam int QB_W = T2_W - T2_LO_W + LIN_W + 1;

    localparam int T3_W = 75;
    localparam int T3_CH_W = 25;
    localparam int RA_W = T3_CH_W + LIN_W;
    localparam int RC_W = T3_CH_W + LIN_W + 1;

    localparam int T4_W = 93;
    localparam int FRAC_W = 60;
    localparam int INT_W = T4_W - 1 - FRAC_W;

    // Reciprocal of 2500 scaled by 2^41, rounded up; exact for 29-bit dividends.
    localparam logic [RECIP_W-1:0] RECIP_2500 = 30'd879609303;

    // Correction coefficients as multiples of 2^-60.
    localparam logic [C4_W-1:0] C4 = 20'd693309;
    localparam logic [C3_W-1:0] C3 = 34'd10828699940;
    localparam logic [C2_W-1:0] C2 = 47'd93949267567403;
    localparam logic [C1_W-1:0] C1 = 61'd1155573224067442724;

    localparam logic [LIN_W-1:0] LUX_LIMIT = 17'd1000;
    localparam logic [LUX_W-1:0] LUX_MAX   = 27'd134217727;

    localparam logic CFG_GAIN  = 1'b0;
    localparam logic CFG_INTEG = 1'b1;

    localparam logic [GAIN_W-1:0] GAIN_X1   = 2'd0;
    localparam logic [GAIN_W-1:0] GAIN_X2   = 2'd1;
    localparam logic [GAIN_W-1:0] GAIN_X1_8 = 2'd2;
    localparam logic [GAIN_W-1:0] GAIN_X1_4 = 2'd3;

    localparam logic [INTEG_W-1:0] INTEG_100MS = 4'd0;
    localparam logic [INTEG_W-1:0] INTEG_200MS = 4'd1;
    localparam logic [INTEG_W-1:0] INTEG_400MS = 4'd2;
    localparam logic [INTEG_W-1:0] INTEG_800MS = 4'd3;
    localparam logic [INTEG_W-1:0] INTEG_50MS  = 4'd8;
    localparam logic [INTEG_W-1:0] INTEG_25MS  = 4'd12;

    typedef struct packed {
        logic vld;
        logic bad;
        logic corr;
    } t_meta;

    typedef struct packed {
        logic       bad;
        logic [2:0] shift;
    } t_integ;

    function automatic logic [2:0] gain_shift(input logic [GAIN_W-1:0] code);
        logic [2:0] s;
        case (code)
            GAIN_X1:   s = 3'd1;
            GAIN_X2:   s = 3'd0;
            GAIN_X1_8: s = 3'd4;
            GAIN_X1_4: s = 3'd3;
            default:   s = 3'd0;
        endcase
        return s;
    endfunction

    function automatic t_integ integ_shift(input logic [INTEG_W-1:0] code);
        t_integ r;
        r.bad = 1'b0;
        case (code)
            INTEG_100MS: r.shift = 3'd3;
            INTEG_200MS: r.shift = 3'd2;
            INTEG_400MS: r.shift = 3'd1;
            INTEG_800MS: r.shift = 3'd0;
            INTEG_50MS:  r.shift = 3'd4;
            INTEG_25MS:  r.shift = 3'd5;
            default: begin
                r.shift = 3'd0;
                r.bad   = 1'b1;
            end
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/alc_scale.sv @@
// Front pipeline: scales the raw count by the resolution and starts the correction polynomial.
`default_nettype none

module alc_scale import alc_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_en,
    input  wire logic                    i_valid,
    input  wire logic [RAW_W-1:0]        i_raw_count,
    input  wire logic [GAIN_W-1:0]       i_gain_code,
    input  wire logic [INTEG_W-1:0]      i_integ_code,
    output t_meta                        o_meta,
    output logic [LIN_W-1:0]             o_lin,
    output logic signed [T1_W-1:0]       o_t1
);

    t_integ                   integ;
    logic [K_W-1:0]           k;
    logic [Y_W-1:0]           y;
    logic [X_W-1:0]           n_x;
    logic [LIN_W-1:0]         lin;
    logic [C4_W+LIN_W-1:0]    c4l;
    logic signed [T1_W-1:0]   n_t1;

    t_meta                    r_meta1, r_meta2, r_meta3;
    logic [X_W-1:0]           r_x;
    logic [PROD_W-1:0]        r_prod;
    logic [LIN_W-1:0]         r_lin;
    logic signed [T1_W-1:0]   r_t1;

    always_comb begin
        integ = integ_shift(i_integ_code);
        k     = K_W'(gain_shift(i_gain_code)) + K_W'(integ.shift);
        y     = Y_W'(i_raw_count) << k;
        n_x   = {1'b0, y, 3'b000} + {4'd0, y};
        lin   = r_prod[RECIP_SHIFT +: LIN_W];
        c4l   = C4 * lin;
        n_t1  = $signed({1'b0, c4l}) - $signed({{(T1_W-C3_W){1'b0}}, C3});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meta1 <= '0;
            r_meta2 <= '0;
            r_meta3 <= '0;
        end else if (i_en) begin
            r_meta1.vld  <= i_valid;
            r_meta1.bad  <= integ.bad;
            r_meta1.corr <= 1'b0;
            r_meta2      <= r_meta1;
            r_meta3.vld  <= r_meta2.vld;
            r_meta3.bad  <= r_meta2.bad;
            r_meta3.corr <= lin > LUX_LIMIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_x;
            r_prod <= r_x * RECIP_2500;
            r_lin  <= lin;
            r_t1   <= n_t1;
        end
    end

    assign o_meta = r_meta3;
    assign o_lin  = r_lin;
    assign o_t1   = r_t1;

endmodule

`default_nettype wire

@@ hw/rtl/alc_poly.sv @@
// Back pipeline: Horner evaluation of the correction polynomial and the final lux select.
`default_nettype none

module alc_poly import alc_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_en,
    input  wire t_meta                   i_meta,
    input  wire logic [LIN_W-1:0]        i_lin,
    input  wire logic signed [T1_W-1:0]  i_t1,
    output logic                         o_valid,
    output logic [LUX_W-1:0]             o_lux,
    output logic                         o_bad
);

    t_meta                    r_meta4, r_meta5, r_meta6, r_meta7, r_meta8, r_meta9;
    logic [LIN_W-1:0]         r_lin4, r_lin5, r_lin6, r_lin7, r_lin8;

    logic [PA_W-1:0]          r_pa;
    logic signed [PB_W-1:0]   r_pb;
    logic signed [T2_W-1:0]   r_t2;
    logic [QA_W-1:0]          r_qa;
    logic signed [QB_W-1:0]   r_qb;
    logic signed [T3_W-1:0]   r_t3;
    logic [RA_W-1:0]          r_ra, r_rb;
    logic signed [RC_W-1:0]   r_rc;
    logic [LUX_W-1:0]         r_lux;

    logic signed [PB_W-1:0]   n_pb;
    logic signed [T2_W-1:0]   n_t2;
    logic signed [QB_W-1:0]   n_qb;
    logic signed [T3_W-1:0]   n_t3;
    logic signed [RC_W-1:0]   n_rc;
    logic signed [T4_W-1:0]   t4;
    logic [INT_W-1:0]         whole;
    logic [LUX_W-1:0]         corrected;
    logic [LUX_W-1:0]         n_lux;

    always_comb begin
        n_pb = $signed(i_t1[T1_W-1:T1_LO_W]) * $signed({1'b0, i_lin});
        n_t2 = (T2_W'(r_pb) <<< T1_LO_W)
             + $signed({{(T2_W-PA_W){1'b0}}, r_pa})
             + $signed({{(T2_W-C2_W){1'b0}}, C2});
        n_qb = $signed(r_t2[T2_W-1:T2_LO_W]) * $signed({1'b0, r_lin5});
        n_t3 = (T3_W'(r_qb) <<< T2_LO_W)
             + $signed({{(T3_W-QA_W){1'b0}}, r_qa})
             + $signed({{(T3_W-C1_W){1'b0}}, C1});
        n_rc = $signed(r_t3[T3_W-1:2*T3_CH_W]) * $signed({1'b0, r_lin7});
        t4   = (T4_W'(r_rc) <<< (2*T3_CH_W))
             + $signed({{(T4_W-RA_W-T3_CH_W){1'b0}}, r_rb, {T3_CH_W{1'b0}}})
             + $signed({{(T4_W-RA_W){1'b0}}, r_ra});
        whole = t4[T4_W-2:FRAC_W];
        if (t4[T4_W-1]) begin
            corrected = '0;
        end else if (whole > INT_W'(LUX_MAX)) begin
            corrected = LUX_MAX;
        end else begin
            corrected = whole[LUX_W-1:0];
        end
        if (r_meta8.bad) begin
            n_lux = '0;
        end else if (r_meta8.corr) begin
            n_lux = corrected;
        end else begin
            n_lux = LUX_W'(r_lin8);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meta4 <= '0;
            r_meta5 <= '0;
            r_meta6 <= '0;
            r_meta7 <= '0;
            r_meta8 <= '0;
            r_meta9 <= '0;
        end else if (i_en) begin
            r_meta4 <= i_meta;
            r_meta5 <= r_meta4;
            r_meta6 <= r_meta5;
            r_meta7 <= r_meta6;
            r_meta8 <= r_meta7;
            r_meta9 <= r_meta8;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lin4 <= i_lin;
            r_lin5 <= r_lin4;
            r_lin6 <= r_lin5;
            r_lin7 <= r_lin6;
            r_lin8 <= r_lin7;
            r_pa   <= i_t1[T1_LO_W-1:0] * i_lin;
            r_pb   <= n_pb;
            r_t2   <= n_t2;
            r_qa   <= r_t2[T2_LO_W-1:0] * r_lin5;
            r_qb   <= n_qb;
            r_t3   <= n_t3;
            r_ra   <= r_t3[T3_CH_W-1:0] * r_lin7;
            r_rb   <= r_t3[2*T3_CH_W-1:T3_CH_W] * r_lin7;
            r_rc   <= n_rc;
            r_lux  <= n_lux;
        end
    end

    assign o_valid = r_meta9.vld;
    assign o_lux   = r_lux;
    assign o_bad   = r_meta9.bad;

endmodule

`default_nettype wire

@@ hw/rtl/ambient_light_lux_converter_top.sv @@
// Top level of the ambient light lux converter: configuration registers and flow control.
// Throughput is one beat per clock while the output is not stalled; the nine-stage multiply pipeline sets the latency.
// The whole pipeline holds while a finished output beat is stalled.
// Synchronous reset clears both configuration registers to zero and empties the pipeline.
`default_nettype none

module ambient_light_lux_converter_top import alc_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic                i_cfg_index,
    input  wire logic [CFG_W-1:0]    i_cfg_data,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [RAW_W-1:0]    i_raw_count,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic [LUX_W-1:0]         o_lux_value,
    output logic                     o_bad_setting
);

    logic [GAIN_W-1:0]       r_gain_code;
    logic [INTEG_W-1:0]      r_integ_code;
    logic                    en;
    t_meta                   meta3;
    logic [LIN_W-1:0]        lin3;
    logic signed [T1_W-1:0]  t1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_code  <= '0;
            r_integ_code <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_GAIN:  r_gain_code  <= i_cfg_data[GAIN_W-1:0];
                CFG_INTEG: r_integ_code <= i_cfg_data[INTEG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The pipeline advances unless the output beat is held by the consumer.
    assign en         = !(o_out_valid && i_out_stall);
    assign o_in_stall = !en;

    alc_scale u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_valid      (i_in_valid),
        .i_raw_count  (i_raw_count),
        .i_gain_code  (r_gain_code),
        .i_integ_code (r_integ_code),
        .o_meta       (meta3),
        .o_lin        (lin3),
        .o_t1         (t1)
    );

    alc_poly u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_meta  (meta3),
        .i_lin   (lin3),
        .i_t1    (t1),
        .o_valid (o_out_valid),
        .o_lux   (o_lux_value),
        .o_bad   (o_bad_setting)
    );

endmodule

`default_nettype wire
